[hw/rtl/asmg_pkg.sv]
// asmg_pkg: shared types and constants of the audio sync-marker gate
// used by asmg_cfg, asmg_name, the top level and the bench; depends on nothing

package asmg_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_SEARCH_POSITION = 3'd0;
	localparam logic [2:0] CFG_SYNC_START      = 3'd1;
	localparam logic [2:0] CFG_SONG_END_STOP   = 3'd2;
	localparam logic [2:0] CFG_EXPAND_TRACKS   = 3'd3;
	localparam logic [2:0] CFG_CUT_TRACKS      = 3'd4;
	localparam logic [2:0] CFG_HALT_ON_STOP    = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// pattern tables, entry 0 in the low word
	localparam logic [3:0][31:0] TONE_PATTERN =
		{32'h1000_1000, 32'h1000_1000, 32'h1000_1000, 32'h0000_0000};
	localparam logic [3:0][31:0] BLIP_PATTERN =
		{32'h5219_5376, 32'h5219_5376, 32'h5219_5376, 32'h5219_5376};

	localparam logic [3:0] BLIP_COUNT_MAX = 4'd15;

	// configuration register file contents
	typedef struct packed {
		logic [31:0] search_position;
		logic        sync_start;
		logic        song_end_stop;
		logic [1:0]  expand_tracks;
		logic [1:0]  cut_tracks;
		logic        halt_on_stop;
	} cfg_t;

	// name extraction result for one item
	typedef struct packed {
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic [1:0] count;
		logic       complete;
	} name_t;

endpackage

[hw/rtl/asmg_cfg.sv]
// asmg_cfg: configuration register file of the sync-marker gate
// depends on asmg_pkg

module asmg_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [asmg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [asmg_pkg::CFG_DATA_W-1:0]   cfg_data,
	output asmg_pkg::cfg_t                    cfg
);

	asmg_pkg::cfg_t cfg_q;

	// register writes, values masked to register width, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				asmg_pkg::CFG_SEARCH_POSITION: cfg_q.search_position <= cfg_data;
				asmg_pkg::CFG_SYNC_START:      cfg_q.sync_start      <= cfg_data[0];
				asmg_pkg::CFG_SONG_END_STOP:   cfg_q.song_end_stop   <= cfg_data[0];
				asmg_pkg::CFG_EXPAND_TRACKS:   cfg_q.expand_tracks   <= cfg_data[1:0];
				asmg_pkg::CFG_CUT_TRACKS:      cfg_q.cut_tracks      <= cfg_data[1:0];
				asmg_pkg::CFG_HALT_ON_STOP:    cfg_q.halt_on_stop    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/asmg_matcher.sv]
// asmg_matcher: four-sample pattern matcher with its position register
// no package dependency; the pattern tables from asmg_pkg are passed in by the parent

module asmg_matcher #(
	parameter logic [3:0][31:0] PATTERN         = '0,
	parameter int               PATTERN_SAMPLES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] sample,
	output logic        hit
);

	logic [1:0] pos_q;
	logic [1:0] pos_d;
	logic [2:0] step;
	logic       adv;
	logic       raw_hit;

	// compare against the expected entry, retry once from the first entry
	always_comb begin
		adv  = 1'b0;
		step = 3'd0;
		if (sample == PATTERN[pos_q]) begin
			adv  = 1'b1;
			step = {1'b0, pos_q} + 3'd1;
		end else if (pos_q != 2'd0 && sample == PATTERN[0]) begin
			adv  = 1'b1;
			step = 3'd1;
		end
		raw_hit = adv && (step >= 3'(PATTERN_SAMPLES));
		pos_d   = (adv && !raw_hit) ? step[1:0] : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (en) begin
			pos_q <= pos_d;
		end
	end

	assign hit = en && raw_hit;

endmodule

[hw/rtl/asmg_name.sv]
// asmg_name: name byte extraction after the first blip
// depends on asmg_pkg for the name_t result type

module asmg_name #(
	parameter int NAME_LENGTH = 16,
	parameter int NAME_DELAY  = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [31:0]    sample,
	input  logic [31:0]    sample_number,
	input  logic           one_blip,
	input  logic           first_blip,
	output asmg_pkg::name_t name
);

	logic [4:0]  done_q;
	logic [4:0]  done_d;
	logic [31:0] start_q;
	logic        active;
	logic [4:0]  done_inc;

	// extraction window: name incomplete, one blip counted, start sample reached
	always_comb begin
		active      = en && (done_q < 5'(NAME_LENGTH)) && one_blip &&
			(sample_number >= start_q);
		done_inc    = done_q + 5'd1;
		done_d      = done_q;
		name.byte_a = 8'd0;
		name.byte_b = 8'd0;
		name.count  = 2'd0;
		if (active) begin
			if (done_q == 5'd0) begin
				// first name byte is skipped, only byte 0 taken
				name.byte_a = sample[7:0];
				name.count  = 2'd1;
				done_d      = done_inc;
			end else begin
				name.byte_a = sample[15:8];
				name.count  = 2'd1;
				done_d      = done_inc;
				if (done_inc < 5'(NAME_LENGTH)) begin
					name.byte_b = sample[7:0];
					name.count  = 2'd2;
					done_d      = done_q + 5'd2;
				end
			end
		end
		name.complete = done_d >= 5'(NAME_LENGTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 5'd0;
			start_q <= 32'd0;
		end else begin
			done_q <= done_d;
			if (en && first_blip) begin
				start_q <= sample_number + 32'(NAME_DELAY);
			end
		end
	end

endmodule

[hw/rtl/audio_sync_marker_gate.sv]
// audio_sync_marker_gate: top level of the sync-marker gate for stereo samples
// depends on asmg_pkg, asmg_cfg, asmg_matcher and asmg_name

// One 32-bit stereo sample enters per item and one result item leaves for it.
// An item is held in the input register and is then evaluated in a
// single pass (tone and blip matchers, name extraction, blip bookkeeping and
// copy gate) into the result register, so a new item is taken every cycle
// while the result side keeps up. The sequence state (sample counter, blip
// count, segment lengths, copy gate) is updated, unless halted, in the same
// edge that loads the result register, which sets the rate at one item per
// cycle while the result side keeps up. Configuration writes take effect on
// the next cycle and are meant to be made while no item is in flight.

module audio_sync_marker_gate #(
	parameter int NAME_LENGTH     = 16,
	parameter int NAME_DELAY      = 11,
	parameter int PATTERN_SAMPLES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [asmg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [asmg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       sample_out,
	output logic                              copy_valid,
	output logic                              preamble_request,
	output logic                              tone_event,
	output logic                              blip_event,
	output logic [31:0]                       segment_length,
	output logic [7:0]                        name_byte_a,
	output logic [7:0]                        name_byte_b,
	output logic [1:0]                        name_byte_count,
	output logic                              name_complete,
	output logic                              stop_event,
	output logic [31:0]                       song_length
);

	asmg_pkg::cfg_t  cfg;
	asmg_pkg::name_t name;

	logic        valid_s1;
	logic [31:0] sample_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        step;
	logic        go;

	logic [31:0] count_q;
	logic        tone_found_q;
	logic [3:0]  blip_count_q;
	logic [31:0] last_blip_q;
	logic [31:0] longest_q;
	logic        copy_active_q;
	logic        start_pending_q;
	logic        halted_q;

	logic [31:0] sc;
	logic        tone_hit;
	logic        blip_hit;
	logic [3:0]  blip_count_d;
	logic [31:0] seg;
	logic [31:0] longest_d;
	logic        pend_set;
	logic        stop_exp;
	logic        stop_cut;
	logic        song_end;
	logic        stop;
	logic        active_now;
	logic        pend_d;

	// configuration registers
	asmg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: input register advances when the result register is free
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign go       = step && !halted_q;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample_in;
		end
	end

	assign sc = count_q + 32'd1;

	// sync tone, searched until first found
	asmg_matcher #(
		.PATTERN         (asmg_pkg::TONE_PATTERN),
		.PATTERN_SAMPLES (PATTERN_SAMPLES)
	) u_tone (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (go && !tone_found_q),
		.sample (sample_s1),
		.hit    (tone_hit)
	);

	// sync blip, searched on every sample while not halted
	asmg_matcher #(
		.PATTERN         (asmg_pkg::BLIP_PATTERN),
		.PATTERN_SAMPLES (PATTERN_SAMPLES)
	) u_blip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (go),
		.sample (sample_s1),
		.hit    (blip_hit)
	);

	// name extraction sees the blip count before this item's blip
	asmg_name #(
		.NAME_LENGTH (NAME_LENGTH),
		.NAME_DELAY  (NAME_DELAY)
	) u_name (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (go),
		.sample        (sample_s1),
		.sample_number (sc),
		.one_blip      (blip_count_q == 4'd1),
		.first_blip    (blip_hit && blip_count_d == 4'd1),
		.name          (name)
	);

	// blip bookkeeping, segment length and stop triggers
	always_comb begin
		blip_count_d = blip_count_q;
		if (blip_hit && blip_count_q != asmg_pkg::BLIP_COUNT_MAX) begin
			blip_count_d = blip_count_q + 4'd1;
		end
		seg       = sc - last_blip_q;
		longest_d = longest_q;
		if (blip_hit && blip_count_d >= 4'd4 && seg > longest_q) begin
			longest_d = seg;
		end
		stop_exp = blip_hit && cfg.expand_tracks != 2'd0 &&
			blip_count_d == ({2'b00, cfg.expand_tracks} + 4'd3);
		stop_cut = blip_hit && cfg.cut_tracks != 2'd0 &&
			blip_count_d == ({2'b00, cfg.cut_tracks} + 4'd3);
		// with a blip on this item the end sample is this one plus the new longest
		song_end = cfg.song_end_stop && copy_active_q && blip_count_d >= 4'd6 &&
			(blip_hit ? (longest_d == 32'd0) : (sc == last_blip_q + longest_q));
		stop = go && (stop_exp || stop_cut || song_end);
	end

	// start triggers and copy gate
	always_comb begin
		pend_set = (cfg.search_position != 32'd0 && sc == cfg.search_position) ||
			(tone_hit && cfg.sync_start);
		pend_d     = start_pending_q || pend_set;
		active_now = copy_active_q;
		if (pend_d && !copy_active_q) begin
			active_now = 1'b1;
			pend_d     = 1'b0;
		end
	end

	// sequence state, updated only for items that are not ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= 32'd0;
			tone_found_q    <= 1'b0;
			blip_count_q    <= 4'd0;
			last_blip_q     <= 32'd0;
			longest_q       <= 32'd0;
			copy_active_q   <= 1'b0;
			start_pending_q <= 1'b0;
			halted_q        <= 1'b0;
		end else if (go) begin
			count_q         <= sc;
			tone_found_q    <= tone_found_q || tone_hit;
			blip_count_q    <= blip_count_d;
			longest_q       <= longest_d;
			start_pending_q <= pend_d;
			copy_active_q   <= active_now && !stop;
			halted_q        <= stop && cfg.halt_on_stop;
			if (blip_hit) begin
				last_blip_q <= sc;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sample_out       <= sample_s1;
			copy_valid       <= go && active_now;
			preamble_request <= tone_hit && cfg.sync_start;
			tone_event       <= tone_hit;
			blip_event       <= blip_hit;
			segment_length   <= blip_hit ? seg : 32'd0;
			name_byte_a      <= name.byte_a;
			name_byte_b      <= name.byte_b;
			name_byte_count  <= name.count;
			name_complete    <= name.complete;
			stop_event       <= stop;
			song_length      <= go ? longest_d : longest_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/asmg_checker.sv]
// asmg_checker: port-level assertions for the sync-marker gate, bound to the top
// depends on audio_sync_marker_gate port list

module asmg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sample_out,
	input logic        preamble_request,
	input logic        tone_event,
	input logic        blip_event,
	input logic [31:0] segment_length,
	input logic [7:0]  name_byte_b,
	input logic [1:0]  name_byte_count
);

	// offered input item stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item withdrawn before acceptance");

	// stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) &&
		$stable(segment_length))
		else $error("result item changed while stalled");

	// preamble only asked for on the tone sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && preamble_request |-> tone_event)
		else $error("preamble request without tone");

	// segment length shown only with a blip
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !blip_event |-> segment_length == 32'd0)
		else $error("segment length without blip");

	// second name byte only when two bytes taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_byte_count != 2'd2 |-> name_byte_b == 8'd0)
		else $error("stray second name byte");

endmodule

bind audio_sync_marker_gate asmg_checker u_asmg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.sample_out       (sample_out),
	.preamble_request (preamble_request),
	.tone_event       (tone_event),
	.blip_event       (blip_event),
	.segment_length   (segment_length),
	.name_byte_b      (name_byte_b),
	.name_byte_count  (name_byte_count)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for the audio sync-marker gate
// drives samples and register writes, predicts every result item and checks it
// depends on asmg_pkg and audio_sync_marker_gate

module testbench;

	localparam int          RESET_CYCLES  = 7;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          CYCLE_LIMIT   = 200_000;
	localparam int          REPORT_LIMIT  = 100;
	localparam logic [4:0]  NAME_LEN      = 5'd16;
	localparam logic [31:0] NAME_DELAY    = 32'd11;

	// sync words: tone is a zero lead word then three body words, blip is four body words
	localparam logic [31:0] TONE_LEAD = 32'h0000_0000;
	localparam logic [31:0] TONE_WORD = 32'h1000_1000;
	localparam logic [31:0] BLIP_WORD = 32'h5219_5376;

	// register indexes with no register behind them
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;

	typedef enum logic [1:0] {RX_STREAM, RX_LIGHT, RX_EVERY_THIRD, RX_HEAVY} rx_mode_e;

	typedef struct packed {
		logic [31:0] sample_out;
		logic        copy_valid;
		logic        preamble_request;
		logic        tone_event;
		logic        blip_event;
		logic [31:0] segment_length;
		logic [7:0]  name_byte_a;
		logic [7:0]  name_byte_b;
		logic [1:0]  name_byte_count;
		logic        name_complete;
		logic        stop_event;
		logic [31:0] song_length;
	} gate_result_t;

	typedef struct packed {
		logic [31:0] word;
		logic        fixed;
		logic        tone;
		logic        blip;
		logic        copy;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_write = 1'b0;
	logic [asmg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [asmg_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [31:0] sample_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] sample_out;
	logic        copy_valid;
	logic        preamble_request;
	logic        tone_event;
	logic        blip_event;
	logic [31:0] segment_length;
	logic [7:0]  name_byte_a;
	logic [7:0]  name_byte_b;
	logic [1:0]  name_byte_count;
	logic        name_complete;
	logic        stop_event;
	logic [31:0] song_length;

	// gate state as the bench sees it
	asmg_pkg::cfg_t gate_cfg   = '0;
	logic [31:0] sample_num    = '0;
	logic [1:0]  tone_pos      = '0;
	logic        tone_seen     = 1'b0;
	logic [1:0]  blip_pos      = '0;
	logic [3:0]  blips         = '0;
	logic [31:0] last_blip_at  = '0;
	logic [31:0] longest_seg   = '0;
	logic [31:0] name_from     = '0;
	logic [4:0]  name_taken    = '0;
	logic        copying       = 1'b0;
	logic        start_waiting = 1'b0;
	logic        frozen        = 1'b0;

	gate_result_t pending_outcomes[$];
	int           mismatch_count = 0;
	int           result_index   = 0;
	int           burst_left     = 0;
	int           cycle_count    = 0;
	bit           hold_request   = 1'b0;

	// directed items: a broken blip, a whole blip, tone with a restart, extremes, then the name run
	stim_row_t directed_rows [0:25] = '{
		'{BLIP_WORD,    1'b1, 1'b0, 1'b0, 1'b0},
		'{BLIP_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_LEAD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{BLIP_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{BLIP_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{BLIP_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{BLIP_WORD,    1'b1, 1'b0, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_LEAD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_LEAD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_WORD,    1'b0, 1'b0, 1'b0, 1'b0},
		'{TONE_WORD,    1'b1, 1'b1, 1'b0, 1'b1},
		'{TONE_WORD,    1'b1, 1'b0, 1'b0, 1'b1},
		'{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h9C3E_4E41, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h0F21_4D42, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'hE507_4C43, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h33AA_FF00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h6B19_00FF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'hC0DE_2D5F, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h1248_3031, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'hA5F0_7A61, 1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h5A0F_3F20, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	audio_sync_marker_gate u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_in        (sample_in),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample_out       (sample_out),
		.copy_valid       (copy_valid),
		.preamble_request (preamble_request),
		.tone_event       (tone_event),
		.blip_event       (blip_event),
		.segment_length   (segment_length),
		.name_byte_a      (name_byte_a),
		.name_byte_b      (name_byte_b),
		.name_byte_count  (name_byte_count),
		.name_complete    (name_complete),
		.stop_event       (stop_event),
		.song_length      (song_length)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one step of a four-word matcher; a miss at a nonzero position retries the lead word
	function automatic logic match_advance(input logic [31:0] word, input logic [31:0] lead,
			input logic [31:0] body, inout logic [1:0] pos);
		logic [1:0] p;
		p = pos;
		if (word != ((p == 2'd0) ? lead : body)) begin
			if (p == 2'd0)
				return 1'b0;
			p = 2'd0;
			if (word != lead) begin
				pos = 2'd0;
				return 1'b0;
			end
		end
		if (p == 2'd3) begin
			pos = 2'd0;
			return 1'b1;
		end
		pos = p + 2'd1;
		return 1'b0;
	endfunction

	// advances the gate state by one accepted item and returns the result it gives
	function automatic gate_result_t gate_outcome(input logic [31:0] word);
		gate_result_t r;
		logic [31:0]  num;
		logic         stop_now;
		r = '0;
		r.sample_out = word;
		stop_now = 1'b0;

		// halted: pass through, state frozen
		if (frozen) begin
			r.name_complete = (name_taken >= NAME_LEN);
			r.song_length = longest_seg;
			return r;
		end

		sample_num = sample_num + 32'd1;
		num = sample_num;

		// search trigger
		if (gate_cfg.search_position != 32'd0 && num == gate_cfg.search_position)
			start_waiting = 1'b1;

		// tone, looked for only until first found
		if (!tone_seen && match_advance(word, TONE_LEAD, TONE_WORD, tone_pos)) begin
			tone_seen = 1'b1;
			r.tone_event = 1'b1;
			if (gate_cfg.sync_start) begin
				r.preamble_request = 1'b1;
				start_waiting = 1'b1;
			end
		end

		// name bytes, first byte of the stream skipped
		if (name_taken < NAME_LEN && blips == 4'd1 && num >= name_from) begin
			r.name_byte_count = 2'd1;
			if (name_taken == 5'd0) begin
				r.name_byte_a = word[7:0];
				name_taken++;
			end else begin
				r.name_byte_a = word[15:8];
				name_taken++;
				if (name_taken < NAME_LEN) begin
					r.name_byte_b = word[7:0];
					r.name_byte_count = 2'd2;
					name_taken++;
				end
			end
		end

		// blip bookkeeping and track-count stops
		if (match_advance(word, BLIP_WORD, BLIP_WORD, blip_pos)) begin
			r.blip_event = 1'b1;
			if (blips != 4'd15)
				blips++;
			if (blips == 4'd1)
				name_from = num + NAME_DELAY;
			r.segment_length = num - last_blip_at;
			if (blips >= 4'd4 && r.segment_length > longest_seg)
				longest_seg = r.segment_length;
			if (gate_cfg.expand_tracks != 2'd0 && blips == {2'b00, gate_cfg.expand_tracks} + 4'd3)
				stop_now = 1'b1;
			if (gate_cfg.cut_tracks != 2'd0 && blips == {2'b00, gate_cfg.cut_tracks} + 4'd3)
				stop_now = 1'b1;
			last_blip_at = num;
		end

		// song end
		if (gate_cfg.song_end_stop && copying && blips >= 4'd6 &&
				num == last_blip_at + longest_seg)
			stop_now = 1'b1;

		// copy gate
		if (start_waiting && !copying) begin
			copying = 1'b1;
			start_waiting = 1'b0;
		end
		r.copy_valid = copying;
		if (stop_now) begin
			copying = 1'b0;
			if (gate_cfg.halt_on_stop)
				frozen = 1'b1;
		end

		r.stop_event = stop_now;
		r.name_complete = (name_taken >= NAME_LEN);
		r.song_length = longest_seg;
		return r;
	endfunction

	// filler word, now and then one of the special values
	function automatic logic [31:0] noise_word();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return TONE_WORD;
			3: return BLIP_WORD;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch at result %0d: %s", result_index, what);
	endtask

	task automatic compare_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, predicted %h", field, got, want));
	endtask

	// sender: bursts of items with random gaps; fixed fields override the prediction
	task automatic send_sample(input logic [31:0] word, input bit fixed = 1'b0,
			input bit tone = 1'b0, input bit blip = 1'b0, input bit copy = 1'b0);
		gate_result_t r;
		int           gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_in <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = gate_outcome(word);
		if (fixed) begin
			r.tone_event = tone;
			r.blip_event = blip;
			r.copy_valid = copy;
		end
		pending_outcomes.push_back(r);
	endtask

	// songs: mostly whole blips with random gaps, some broken blips and plain noise
	task automatic send_songs(input int item_goal, input int max_gap, input bit long_gaps);
		int sent;
		int run;
		int pick;
		sent = 0;
		while (sent < item_goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				repeat (4) send_sample(BLIP_WORD);
				sent += 4;
				if (long_gaps && $urandom_range(0, 5) == 0)
					run = longest_seg + $urandom_range(1, 12);
				else
					run = $urandom_range(1, max_gap);
			end else if (pick < 9) begin
				repeat ($urandom_range(1, 3)) send_sample(BLIP_WORD);
				sent += 2;
				run = $urandom_range(1, 4);
			end else begin
				run = $urandom_range(1, max_gap);
			end
			repeat (run) send_sample(noise_word());
			sent += run;
		end
	endtask

	// stop offering and let every predicted item come out
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// writes all six registers, narrow ones with junk above their width, plus the spares
	task automatic load_settings(input logic [31:0] search, input bit sync, input bit song_end,
			input logic [1:0] expand, input logic [1:0] cut, input bit halt);
		write_reg(asmg_pkg::CFG_SEARCH_POSITION, search);
		write_reg(asmg_pkg::CFG_SYNC_START, ($urandom & 32'hFFFF_FFFE) | {31'd0, sync});
		write_reg(asmg_pkg::CFG_SONG_END_STOP,
			($urandom & 32'hFFFF_FFFE) | {31'd0, song_end});
		write_reg(asmg_pkg::CFG_EXPAND_TRACKS, ($urandom & 32'hFFFF_FFFC) | {30'd0, expand});
		write_reg(asmg_pkg::CFG_CUT_TRACKS, ($urandom & 32'hFFFF_FFFC) | {30'd0, cut});
		write_reg(asmg_pkg::CFG_HALT_ON_STOP, ($urandom & 32'hFFFF_FFFE) | {31'd0, halt});
		write_reg(CFG_SPARE_A, $urandom);
		write_reg(CFG_SPARE_B, $urandom);
		cfg_write <= 1'b0;
		gate_cfg.search_position = search;
		gate_cfg.sync_start = sync;
		gate_cfg.song_end_stop = song_end;
		gate_cfg.expand_tracks = expand;
		gate_cfg.cut_tracks = cut;
		gate_cfg.halt_on_stop = halt;
	endtask

	// receiver: changing stall patterns, and a long hold-off on request
	always @(posedge clk) begin : drive_ready
		int       hold_left;
		int       mode_left;
		int       tick;
		bit       hold_used;
		rx_mode_e ready_mode;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left <= 0) begin
				ready_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			tick++;
			case (ready_mode)
				RX_STREAM:      out_ready <= 1'b1;
				RX_LIGHT:       out_ready <= ($urandom_range(0, 9) >= 3);
				RX_EVERY_THIRD: out_ready <= (tick % 3 == 0);
				default:        out_ready <= ($urandom_range(0, 9) >= 7);
			endcase
		end
	end

	// result checking against the oldest prediction
	always @(posedge clk) begin : check_results
		gate_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result item with no item waiting for it");
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("sample_out", sample_out, want.sample_out);
				compare_field("copy_valid", copy_valid, want.copy_valid);
				compare_field("preamble_request", preamble_request, want.preamble_request);
				compare_field("tone_event", tone_event, want.tone_event);
				compare_field("blip_event", blip_event, want.blip_event);
				compare_field("segment_length", segment_length, want.segment_length);
				compare_field("name_byte_a", name_byte_a, want.name_byte_a);
				compare_field("name_byte_b", name_byte_b, want.name_byte_b);
				compare_field("name_byte_count", name_byte_count, want.name_byte_count);
				compare_field("name_complete", name_complete, want.name_complete);
				compare_field("stop_event", stop_event, want.stop_event);
				compare_field("song_length", song_length, want.song_length);
			end
			result_index++;
		end
	end

	// stimulus
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// search off, start on tone, stop at blip four and again at six while idle
		load_settings(32'd0, 1'b1, 1'b0, 2'd1, 2'd3, 1'b0);
		foreach (directed_rows[i])
			send_sample(directed_rows[i].word, directed_rows[i].fixed,
				directed_rows[i].tone, directed_rows[i].blip, directed_rows[i].copy);
		send_songs(70, 30, 1'b0);
		drain_results();

		// search start with song-end stop, short gaps so copying tends to run on
		load_settings(sample_num + 32'd8, 1'b0, 1'b1, 2'd3, 2'd0, 1'b0);
		send_songs(50, 10, 1'b0);
		drain_results();

		// search start likely while copying, long gaps for song-end stops, receiver hold-off
		load_settings(sample_num + 32'd5, 1'b1, 1'b1, 2'd2, 2'd2, 1'b0);
		hold_request = 1'b1;
		send_songs(70, 30, 1'b1);
		drain_results();
		send_songs(70, 30, 1'b1);
		drain_results();

		// search at the top of the counter, never reached
		load_settings(32'hFFFF_FFFF, 1'b0, 1'b0, 2'd1, 2'd2, 1'b0);
		send_songs(60, 40, 1'b1);
		drain_results();

		// halt on stop, last since only reset leaves it; a long quiet run forces song end
		load_settings(sample_num + 32'd4, 1'b0, 1'b1, 2'd0, 2'd1, 1'b1);
		send_songs(60, 30, 1'b1);
		repeat (longest_seg + 24) send_sample($urandom);
		drain_results();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
